>>> src/srs_pkg.sv
// Shared types and constants for the scaled rank sorter.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package srs_pkg;

    // Default capacity of the value chain.
    localparam int DEF_MAX_ITEMS = 64;

    // Fixed field widths of the ports.
    localparam int VALUE_W = 32;
    localparam int ITEM_W  = 6;
    localparam int SCORE_W = 7;

    // Scaling: score = floor((198*r + d) / (2*d)), d = n - 1.
    localparam int SCALE_NUM = 198;
    localparam int SCORE_MAX = 99;

    // Serial divider: one quotient bit per cycle, quotient always below 2**SCORE_W.
    localparam int DIV_CNT_W = 3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RANK,
        ST_DIV,
        ST_OUT
    } srs_state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic start;   // load own value into the token register, clear rank
        logic step;    // compare the visiting token, pass it to the neighbor
        logic shift;   // move ranks one cell toward the head
    } cell_ctrl_t;

endpackage

>>> src/srs_cell.sv
// One cell of the ranking ring: holds a stored value, a circulating token and a rank.
// Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_cell #(
    parameter int MAX_ITEMS = srs_pkg::DEF_MAX_ITEMS,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = $clog2(MAX_ITEMS)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  srs_pkg::cell_ctrl_t                ctrl,
    input  logic                               wr_en,
    input  logic signed [srs_pkg::VALUE_W-1:0] wr_value,
    input  logic                               live,
    input  logic signed [srs_pkg::VALUE_W-1:0] prev_tok_key,
    input  logic [IDX_W-1:0]                   prev_tok_idx,
    input  logic                               prev_tok_vld,
    input  logic [IDX_W-1:0]                   next_rank,
    output logic signed [srs_pkg::VALUE_W-1:0] tok_key,
    output logic [IDX_W-1:0]                   tok_idx,
    output logic                               tok_vld,
    output logic [IDX_W-1:0]                   rank
);
    import srs_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] tok_key_reg;
    logic [IDX_W-1:0]          tok_idx_reg;
    logic                      tok_vld_reg;
    logic [IDX_W-1:0]          rank_reg;
    logic                      beats;

    // The visiting value ranks below ours; ties go to the earlier load.
    assign beats = tok_vld_reg &&
                   ((tok_key_reg < key_reg) ||
                    ((tok_key_reg == key_reg) && (tok_idx_reg < MY_IDX)));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg <= wr_value;
        end
        if (ctrl.start) begin
            tok_key_reg <= key_reg;
            tok_idx_reg <= MY_IDX;
        end else if (ctrl.step) begin
            tok_key_reg <= prev_tok_key;
            tok_idx_reg <= prev_tok_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
            rank_reg    <= '0;
        end else if (ctrl.start) begin
            tok_vld_reg <= live;
            rank_reg    <= '0;
        end else if (ctrl.step) begin
            tok_vld_reg <= prev_tok_vld;
            if (beats) begin
                rank_reg <= rank_reg + IDX_W'(1);
            end
        end else if (ctrl.shift) begin
            rank_reg <= next_rank;
        end
    end

    assign tok_key = tok_key_reg;
    assign tok_idx = tok_idx_reg;
    assign tok_vld = tok_vld_reg;
    assign rank    = rank_reg;

endmodule

>>> src/scaled_rank_sorter_top.sv
// Top level of the scaled rank sorter: load chain, ranking ring and serial scaler.
// Depends on srs_pkg and srs_cell.
`timescale 1ns / 1ps

// Scaled rank sorter. Signed Q16.16 values come in one beat per cycle on the
// s_ channel and are kept in load order, one per cell, up to MAX_ITEMS of
// them; beats past capacity are dropped, but a dropped beat marked s_last
// still closes the set. After the last beat the block ranks the set: every
// cell launches its value as a token around a ring of cells, the tokens
// advance one cell per cycle, and each cell counts the tokens that sort
// below its own value (equal values rank by load position, earlier first).
// Results then leave in load order on the m_ channel, one beat per stored
// value, carrying the load position, the rank scaled to 0..99 with
// round-half-up (0 when only one value was loaded) and a flag on the final
// beat. Each result passes through a shared restoring divider that yields
// one quotient bit per cycle; its output beat then holds until m_ready is
// high. While ranking and emitting, s_ready is low; the next set is
// accepted from the cycle after the final result beat.
module scaled_rank_sorter_top #(
    parameter int MAX_ITEMS = srs_pkg::DEF_MAX_ITEMS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [srs_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [srs_pkg::ITEM_W-1:0]         m_item_index,
    output logic [srs_pkg::SCORE_W-1:0]        m_rank_score,
    output logic                               m_last_result
);
    import srs_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    // Numerator 198*r + d peaks at 199*(MAX_ITEMS-1).
    localparam int NUM_W = $clog2(199 * (MAX_ITEMS - 1) + 1);
    localparam int DEN_W = IDX_W + 1;
    localparam int REM_W = IDX_W + 2;
    localparam logic [NUM_W-1:0]     SCALE_K  = NUM_W'(SCALE_NUM);
    localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_ITEMS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SCORE_W);

    srs_state_t state_reg, state_next;

    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]     emit_reg, emit_next;
    logic [CNT_W-1:0]     step_reg, step_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [REM_W-1:0]     rem_reg;
    logic [SCORE_W-1:0]   num_lo_reg;
    logic [SCORE_W-1:0]   quo_reg;

    cell_ctrl_t           ctrl;
    logic                 in_beat;
    logic                 out_beat;
    logic                 wr_en;
    logic                 div_load;
    logic                 div_step;
    logic                 last_out;
    logic                 single;

    logic [IDX_W-1:0]     span;
    logic [DEN_W-1:0]     den;
    logic [NUM_W-1:0]     num;
    logic [REM_W:0]       trial;
    logic                 trial_ge;

    logic signed [VALUE_W-1:0] tok_key_w [MAX_ITEMS];
    logic [IDX_W-1:0]          tok_idx_w [MAX_ITEMS];
    logic                      tok_vld_w [MAX_ITEMS];
    logic [IDX_W-1:0]          rank_w    [MAX_ITEMS];

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign last_out = ({1'b0, emit_reg} + CNT_W'(1)) == fill_reg;
    assign single   = fill_reg < CNT_W'(2);

    // Divisor 2*(n-1) and numerator 198*r + (n-1) for the rank at the head cell.
    assign span = IDX_W'(fill_reg - CNT_W'(1));
    assign den  = {span, 1'b0};
    assign num  = SCALE_K * NUM_W'(rank_w[0]) + NUM_W'(span);

    // Restoring step: bring down one numerator bit, subtract when it fits.
    assign trial    = {rem_reg, num_lo_reg[SCORE_W-1]};
    assign trial_ge = trial >= (REM_W + 1)'(den);

    // Cell ring: tokens advance toward higher cells and wrap; ranks drain to cell 0.
    for (genvar p = 0; p < MAX_ITEMS; p++) begin : g_cell
        localparam int PREV = (p + MAX_ITEMS - 1) % MAX_ITEMS;
        logic [IDX_W-1:0] next_rank;

        if (p == MAX_ITEMS - 1) begin : g_tail
            assign next_rank = '0;
        end else begin : g_body
            assign next_rank = rank_w[p + 1];
        end

        srs_cell #(
            .MAX_ITEMS (MAX_ITEMS),
            .CELL_IDX  (p)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .wr_en        (wr_en && (fill_reg == CNT_W'(p))),
            .wr_value     (s_value),
            .live         (fill_reg > CNT_W'(p)),
            .prev_tok_key (tok_key_w[PREV]),
            .prev_tok_idx (tok_idx_w[PREV]),
            .prev_tok_vld (tok_vld_w[PREV]),
            .next_rank    (next_rank),
            .tok_key      (tok_key_w[p]),
            .tok_idx      (tok_idx_w[p]),
            .tok_vld      (tok_vld_w[p]),
            .rank         (rank_w[p])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_beat && s_last) begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK: begin
                if (step_reg == CNT_MAX) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = last_out ? ST_LOAD : ST_DIV;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs and strobes of the sequencer.
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        ctrl       = '0;
        wr_en      = 1'b0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                wr_en   = s_valid;
            end
            ST_RANK: begin
                ctrl.start = (step_reg == '0);
                ctrl.step  = (step_reg != '0);
            end
            ST_DIV: begin
                div_load = (div_cnt_reg == '0);
                div_step = (div_cnt_reg != '0);
            end
            ST_OUT: begin
                m_valid    = 1'b1;
                ctrl.shift = m_ready;
            end
            default: ;
        endcase
    end

    // Counters.
    always_comb begin
        fill_next    = fill_reg;
        emit_next    = emit_reg;
        step_next    = (state_reg == ST_RANK) ? step_reg + CNT_W'(1) : '0;
        div_cnt_next = (state_reg == ST_DIV) ? div_cnt_reg + DIV_CNT_W'(1) : '0;
        if (in_beat && (fill_reg < CNT_MAX)) begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (out_beat) begin
            if (last_out) begin
                fill_next = '0;
                emit_next = '0;
            end else begin
                emit_next = emit_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            emit_reg    <= '0;
            step_reg    <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            emit_reg    <= emit_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Divider datapath; the quotient is below 2**SCORE_W, so the top bits seed the remainder.
    always_ff @(posedge aclk) begin
        if (div_load) begin
            rem_reg    <= REM_W'(num >> SCORE_W);
            num_lo_reg <= num[SCORE_W-1:0];
            quo_reg    <= '0;
        end else if (div_step) begin
            rem_reg    <= trial_ge ? REM_W'(trial - (REM_W + 1)'(den)) : REM_W'(trial);
            num_lo_reg <= {num_lo_reg[SCORE_W-2:0], 1'b0};
            quo_reg    <= {quo_reg[SCORE_W-2:0], trial_ge};
        end
    end

    assign m_item_index  = ITEM_W'(emit_reg);
    assign m_rank_score  = single ? '0 : quo_reg;
    assign m_last_result = last_out;

endmodule

>>> src/srs_checker.sv
// Port-level checks for the scaled rank sorter, bound to the top level.
// Depends on srs_pkg and scaled_rank_sorter_top.
`timescale 1ns / 1ps

module srs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [srs_pkg::ITEM_W-1:0]  m_item_index,
    input logic [srs_pkg::SCORE_W-1:0] m_rank_score,
    input logic                        m_last_result
);
    import srs_pkg::*;

    // Scores stay within the scaled range.
    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rank_score <= SCORE_W'(SCORE_MAX)))
        else $error("rank score above range");

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is shown");

    // The final result beat reopens the input side straight after it.
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> s_ready)
        else $error("input not reopened after final result");

    // Between results the scaler is busy: no result and no input beat next cycle.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_result) |=> (!m_valid && !s_ready))
        else $error("result or input ready right after a non-final result");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_item_index) && $stable(m_rank_score)
             && $stable(m_last_result)))
        else $error("stalled result changed");

endmodule

bind scaled_rank_sorter_top srs_checker u_srs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_item_index  (m_item_index),
    .m_rank_score  (m_rank_score),
    .m_last_result (m_last_result)
);
